// ===== rtl/core/dlr_pkg.sv =====
package dlr_pkg;

  localparam int COORD_MAX = 63;
  localparam int COORD_W = 6;
  localparam int CODE_W = 8;
  localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

// ===== rtl/core/dlr_ctrl.sv =====
module dlr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dlr_pkg::sts_t sts,
  output dlr_pkg::cmd_t cmd
);

  dlr_pkg::state_t state;
  dlr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      dlr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = dlr_pkg::ST_SETUP;
        end
      end
      dlr_pkg::ST_SETUP: begin
        cmd.init = 1'b1;
        state_next = dlr_pkg::ST_EMIT;
      end
      dlr_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_next = dlr_pkg::ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = dlr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dlr_dp.sv =====
module dlr_dp #(
  parameter int COORD_MAX = dlr_pkg::COORD_MAX
) (
  input  logic                         clk,
  input  dlr_pkg::cmd_t                cmd,
  output dlr_pkg::sts_t                sts,
  input  logic [dlr_pkg::COORD_W-1:0]  start_row,
  input  logic [dlr_pkg::COORD_W-1:0]  start_col,
  input  logic [dlr_pkg::COORD_W-1:0]  end_row,
  input  logic [dlr_pkg::COORD_W-1:0]  end_col,
  input  logic [dlr_pkg::CODE_W-1:0]   glyph,
  input  logic                         mode,
  output logic [dlr_pkg::COORD_W-1:0]  row,
  output logic [dlr_pkg::COORD_W-1:0]  col,
  output logic [dlr_pkg::CODE_W-1:0]   char_code,
  output logic                         last
);

  localparam int CW = dlr_pkg::COORD_W;
  localparam logic [CW-1:0] CMAX = CW'(COORD_MAX);

  logic [CW-1:0] s_row, s_col, e_row, e_col;
  logic [CW-1:0] cur_row, cur_col;
  logic [CW-1:0] remain;
  logic [CW:0]   major2, minor2;
  logic [CW+1:0] err;
  logic          row_major, row_neg, col_neg;

  logic [CW-1:0] d_row, d_col, d_major, d_minor;
  logic          neg_row_w, neg_col_w, row_major_w;
  logic [CW+1:0] err_sum;
  logic          wrap;
  logic [CW-1:0] row_inc, col_inc;

  always_comb begin
    neg_row_w = e_row < s_row;
    neg_col_w = e_col < s_col;
    d_row = neg_row_w ? s_row - e_row : e_row - s_row;
    d_col = neg_col_w ? s_col - e_col : e_col - s_col;
    row_major_w = d_row > d_col;
    d_major = row_major_w ? d_row : d_col;
    d_minor = row_major_w ? d_col : d_row;
    err_sum = err + {1'b0, minor2};
    wrap = err_sum >= {1'b0, major2};
    row_inc = row_neg ? cur_row - CW'(1) : cur_row + CW'(1);
    col_inc = col_neg ? cur_col - CW'(1) : cur_col + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_row <= (start_row > CMAX) ? CMAX : start_row;
      s_col <= (start_col > CMAX) ? CMAX : start_col;
      e_row <= (end_row > CMAX) ? CMAX : end_row;
      e_col <= (end_col > CMAX) ? CMAX : end_col;
      char_code <= mode ? glyph : dlr_pkg::SPACE_CODE;
    end
    if (cmd.init) begin
      cur_row <= s_row;
      cur_col <= s_col;
      row_neg <= neg_row_w;
      col_neg <= neg_col_w;
      row_major <= row_major_w;
      major2 <= {d_major, 1'b0};
      minor2 <= {d_minor, 1'b0};
      err <= {2'b00, d_major};
      remain <= d_major;
    end else if (cmd.step) begin
      remain <= remain - CW'(1);
      err <= wrap ? err_sum - {1'b0, major2} : err_sum;
      if (row_major) begin
        cur_row <= row_inc;
        if (wrap) begin
          cur_col <= col_inc;
        end
      end else begin
        cur_col <= col_inc;
        if (wrap) begin
          cur_row <= row_inc;
        end
      end
    end
  end

  assign row = cur_row;
  assign col = cur_col;
  assign last = (remain == '0);
  assign sts.last = last;

endmodule

// ===== rtl/core/dda_line_rasterizer.sv =====
// An accepted line is loaded, a setup state initialises the stepper, then the
// points are offered, one point per cycle while out_ready is high; a line of
// n+1 points (up to COORD_MAX+1) ends before the single stepper takes another.
// Reset: rst is synchronous; it returns the controller to idle and drops any
// line in progress.
module dda_line_rasterizer #(
  parameter int COORD_MAX = dlr_pkg::COORD_MAX
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dlr_pkg::COORD_W-1:0]  start_row,
  input  logic [dlr_pkg::COORD_W-1:0]  start_col,
  input  logic [dlr_pkg::COORD_W-1:0]  end_row,
  input  logic [dlr_pkg::COORD_W-1:0]  end_col,
  input  logic [dlr_pkg::CODE_W-1:0]   glyph,
  input  logic                         mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dlr_pkg::COORD_W-1:0]  row,
  output logic [dlr_pkg::COORD_W-1:0]  col,
  output logic [dlr_pkg::CODE_W-1:0]   char_code,
  output logic                         last
);

  dlr_pkg::cmd_t cmd;
  dlr_pkg::sts_t sts;

  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlr_dp #(
    .COORD_MAX (COORD_MAX)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .start_row (start_row),
    .start_col (start_col),
    .end_row   (end_row),
    .end_col   (end_col),
    .glyph     (glyph),
    .mode      (mode),
    .row       (row),
    .col       (col),
    .char_code (char_code),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a point is offered");

  a_setup_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("point offered without setup cycle");

  a_end_of_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid && in_ready))
    else $error("line did not end after last point");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(row) <= COORD_MAX && int'(col) <= COORD_MAX))
    else $error("point outside grid");
`endif

endmodule
